@@ rtl/core/hsm_pkg.sv @@
// Package for the haptic source mixer: payload structs, register indexes,
// sequencer states and shared constants. No dependencies.
package hsm_pkg;

  localparam int MaxSourcesDefault = 64;
  localparam int EventTypesDefault = 16;
  localparam logic [15:0] CompThreshold = 16'd45875;
  localparam int CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_NATIVE_ONLY  = 3'd0,
    REG_ALLOWED_MASK = 3'd1,
    REG_FOCUS_ACTIVE = 3'd2,
    REG_FOCUS_TYPE   = 3'd3,
    REG_DUCK_GAIN    = 3'd4,
    REG_LIMITER      = 3'd5,
    REG_SLEW         = 3'd6,
    REG_DEADZONE     = 3'd7
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_SCAN,
    ST_EXPIRE,
    ST_READ,
    ST_MULT,
    ST_ACCUM,
    ST_DIV_L,
    ST_DIV_R,
    ST_POST,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic        op;
    logic [3:0]  event_type;
    logic [15:0] source_left;
    logic [15:0] source_right;
    logic [15:0] confidence;
    logic [15:0] ttl_ticks;
    logic [15:0] age_ticks;
  } in_item_t;

  typedef struct packed {
    logic [7:0] left_motor;
    logic [7:0] right_motor;
    logic       frame_valid;
    logic       source_accepted;
    logic [6:0] active_count;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctrl_t;

endpackage

@@ rtl/core/hsm_divider.sv @@
// Restoring divider, one quotient bit per cycle, shared by both channels.
// Depends on hsm_pkg for the control struct.
module hsm_divider #(
  parameter int NumW = 48,
  parameter int DenW = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [NumW-1:0]     num_i,
  input  logic [DenW-1:0]     den_i,
  output hsm_pkg::div_ctrl_t  ctrl_o,
  output logic [NumW-1:0]     quo_o
);
  import hsm_pkg::*;

  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [DenW:0]   trial;

  // One shift and trial subtraction per cycle.
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[DenW-1:0], quo_q[NumW-1]};
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign ctrl_o = '{start: start_i, busy: busy_q, done: done_q};
  assign quo_o  = quo_q;
endmodule

@@ rtl/core/haptic_source_mixer.sv @@
// Top level of the haptic source mixer: source table, sequencer, shared
// multiplier datapath and post-processing. Depends on hsm_pkg, hsm_divider.
//
// An add request walks the table looking for the lowest free slot and
// stops early when a low slot is free or the source is dropped. A tick
// request first makes one expiry pass over every entry. It then makes an
// accumulation pass through the single combinational multiplier. When
// the total weight is not zero, two divisions follow in the shared
// bit-serial divider. busy is high while a request is in work, and start
// is taken only when busy is low. The next request can be taken in the
// cycle that shows the result. Each result is shown for one cycle with
// valid_o high and cannot be held off by the receiver.
module haptic_source_mixer #(
  parameter int MAX_SOURCES = hsm_pkg::MaxSourcesDefault,
  parameter int EVENT_TYPES = hsm_pkg::EventTypesDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  hsm_pkg::in_item_t        item_i,
  output logic                     valid_o,
  output hsm_pkg::out_item_t       result_o,
  input  logic                     cfg_we_i,
  input  logic [hsm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [15:0]              cfg_data_i
);
  import hsm_pkg::*;

  localparam int IdxW = $clog2(MAX_SOURCES);
  localparam int CntW = $clog2(MAX_SOURCES + 1);
  localparam int SumW = 32 + CntW;
  localparam int WSumW = 16 + CntW;

  // Configuration registers.
  logic        native_only_q, focus_active_q;
  logic [15:0] allowed_mask_q, duck_gain_q, limiter_q, deadzone_q;
  logic [3:0]  focus_type_q;
  logic [7:0]  slew_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      native_only_q  <= 1'b0;
      allowed_mask_q <= 16'hFFFF;
      focus_active_q <= 1'b0;
      focus_type_q   <= 4'd0;
      duck_gain_q    <= 16'hFFFF;
      limiter_q      <= 16'hFFFF;
      slew_q         <= 8'hFF;
      deadzone_q     <= 16'd0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_NATIVE_ONLY:  native_only_q  <= cfg_data_i[0];
        REG_ALLOWED_MASK: allowed_mask_q <= cfg_data_i;
        REG_FOCUS_ACTIVE: focus_active_q <= cfg_data_i[0];
        REG_FOCUS_TYPE:   focus_type_q   <= cfg_data_i[3:0];
        REG_DUCK_GAIN:    duck_gain_q    <= cfg_data_i;
        REG_LIMITER:      limiter_q      <= cfg_data_i;
        REG_SLEW:         slew_q         <= cfg_data_i[7:0];
        REG_DEADZONE:     deadzone_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Source table: levels and meta in memory, valid bits in flip-flops.
  logic [47:0] lvl_mem [MAX_SOURCES];
  logic [35:0] meta_mem [MAX_SOURCES];
  logic [MAX_SOURCES-1:0] valid_q, valid_d;
  logic [47:0] lvl_rd_q;
  logic [35:0] meta_rd_q;
  logic        mem_we;
  logic [IdxW-1:0] mem_widx;
  logic [47:0] lvl_wr;
  logic [35:0] meta_wr;

  // Sequencer registers.
  state_e state_q, state_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [CntW-1:0] count_q, count_d;
  logic [31:0] tick_q, tick_d;
  logic [15:0] last_l_q, last_l_d, last_r_q, last_r_d;
  logic [SumW-1:0] sum_l_q, sum_l_d, sum_r_q, sum_r_d;
  logic [WSumW-1:0] sum_w_q, sum_w_d;
  logic [15:0] mix_l_q, mix_l_d;
  logic [15:0] w_q, w_d;
  logic        ducked_q, ducked_d;
  logic [1:0]  mphase_q, mphase_d;
  logic [31:0] prod_q, prod_d;
  logic [15:0] mula, mulb;
  logic [31:0] prod;
  in_item_t    item_q, item_d;
  out_item_t   res_q, res_d;
  logic        valid_q2, valid_d2;
  logic        add_ok;

  // Shared divider.
  logic        div_start;
  div_ctrl_t   div_ctrl;
  logic [SumW-1:0] div_num;
  logic [SumW-1:0] div_quo;

  hsm_divider #(.NumW(SumW), .DenW(WSumW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (sum_w_q),
    .ctrl_o (div_ctrl),
    .quo_o  (div_quo)
  );

  // The one multiplier, operands chosen by the sequencer.
  assign prod = mula * mulb;

  logic [IdxW-1:0] idx_lo;
  assign idx_lo = idx_q[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      lvl_mem[mem_widx]  <= lvl_wr;
      meta_mem[mem_widx] <= meta_wr;
    end
    lvl_rd_q  <= lvl_mem[idx_lo];
    meta_rd_q <= meta_mem[idx_lo];
  end

  // Post-processing of one channel: compressor, limiter, slew.
  function automatic logic [15:0] shape(input logic [15:0] x, input logic [15:0] last,
                                        input logic [15:0] lim, input logic [7:0] slew);
    logic [17:0] over;
    logic [16:0] c;
    logic [16:0] step;
    c = {1'b0, x};
    if (x > CompThreshold) begin
      over = 18'(x - CompThreshold);
      c = 17'(CompThreshold) + 17'((34'(over) * 34'd21846) >> 16);
    end
    if (c > {1'b0, lim}) c = {1'b0, lim};
    step = 17'(slew) * 17'd257;
    if (c > {1'b0, last} && (c - {1'b0, last}) > step) c = {1'b0, last} + step;
    else if ({1'b0, last} > c && ({1'b0, last} - c) > step) c = {1'b0, last} - step;
    return c[15:0];
  endfunction

  function automatic logic [7:0] motor(input logic [15:0] x, input logic [15:0] dz);
    logic [23:0] m;
    m = (x < dz) ? 24'd0 : (24'(x) * 24'd255 + 24'd255);
    return m[23:16];
  endfunction

  logic [15:0] shaped;
  logic [31:0] diff;

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    count_d   = count_q;
    tick_d    = tick_q;
    last_l_d  = last_l_q;
    last_r_d  = last_r_q;
    sum_l_d   = sum_l_q;
    sum_r_d   = sum_r_q;
    sum_w_d   = sum_w_q;
    mix_l_d   = mix_l_q;
    w_d       = w_q;
    ducked_d  = ducked_q;
    mphase_d  = mphase_q;
    prod_d    = prod_q;
    item_d    = item_q;
    res_d     = res_q;
    valid_d2  = 1'b0;
    valid_d   = valid_q;
    mem_we    = 1'b0;
    mem_widx  = idx_lo;
    lvl_wr    = {item_q.confidence, item_q.source_right, item_q.source_left};
    meta_wr   = {tick_q - 32'(item_q.age_ticks) + 32'(item_q.ttl_ticks),
                 item_q.event_type};
    div_start = 1'b0;
    div_num   = sum_l_q;
    mula      = w_q;
    mulb      = duck_gain_q;
    shaped    = '0;
    diff      = tick_q - meta_rd_q[35:4];
    add_ok    = !native_only_q && (item_q.event_type == 4'd0 ||
                 (32'(item_q.event_type) < EVENT_TYPES &&
                  allowed_mask_q[item_q.event_type]));

    unique case (state_q)
      ST_IDLE: begin
        idx_d = '0;
        if (start && !busy) begin
          item_d = item_i;
          res_d  = '0;
          if (item_i.op) begin
            tick_d  = tick_q + 32'd1;
            sum_l_d = '0;
            sum_r_d = '0;
            sum_w_d = '0;
            state_d = ST_EXPIRE;
          end else begin
            state_d = ST_ADD_SCAN;
          end
        end
      end
      // Find the lowest free slot, one entry per cycle.
      ST_ADD_SCAN: begin
        if (!add_ok || idx_q == CntW'(MAX_SOURCES)) begin
          state_d = ST_DONE;
        end else if (!valid_q[idx_lo]) begin
          mem_we          = 1'b1;
          valid_d[idx_lo] = 1'b1;
          count_d         = count_q + 1'b1;
          res_d.source_accepted = 1'b1;
          state_d         = ST_DONE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      // Expiry pass: read settles in ST_READ, compare there. At the end the
      // index returns to zero and an idle pass through ST_MULT lets entry zero be read.
      ST_EXPIRE: begin
        if (idx_q == CntW'(MAX_SOURCES)) begin
          idx_d   = '0;
          state_d = ST_MULT;
          mphase_d = 2'd3;
        end else begin
          state_d = ST_READ;
          mphase_d = 2'd1;
        end
      end
      ST_READ: begin
        if (mphase_q == 2'd1) begin
          // expiry compare on the registered meta word
          if (valid_q[idx_lo] && diff != 32'd0 && !diff[31]) begin
            valid_d[idx_lo] = 1'b0;
            count_d = count_q - 1'b1;
          end
          idx_d   = idx_q + 1'b1;
          state_d = ST_EXPIRE;
        end else if (idx_q == CntW'(MAX_SOURCES)) begin
          state_d = ST_DIV_L;
          div_start = (sum_w_q != '0);
          div_num = sum_l_q;
        end else if (!valid_q[idx_lo]) begin
          idx_d = idx_q + 1'b1;
          state_d = ST_MULT;
          mphase_d = 2'd3;
        end else begin
          w_d      = lvl_rd_q[47:32];
          ducked_d = focus_active_q && meta_rd_q[3:0] != focus_type_q;
          mphase_d = 2'd0;
          state_d  = ST_MULT;
        end
      end
      // Multiply phases: duck weight, then left and right products.
      ST_MULT: begin
        if (mphase_q == 2'd3) begin
          state_d  = ST_READ;
          mphase_d = 2'd0;
        end else begin
          if (ducked_q) begin
            mula = w_q;
            mulb = duck_gain_q;
            w_d  = 16'((33'(prod) + 33'(w_q)) >> 16);
          end
          state_d = ST_ACCUM;
          mphase_d = 2'd0;
        end
      end
      ST_ACCUM: begin
        unique case (mphase_q)
          2'd0: begin
            mula = lvl_rd_q[15:0];
            mulb = w_q;
            sum_l_d = sum_l_q + SumW'(prod);
            sum_w_d = sum_w_q + WSumW'(w_q);
            mphase_d = 2'd1;
          end
          2'd1: begin
            mula = lvl_rd_q[31:16];
            mulb = w_q;
            sum_r_d = sum_r_q + SumW'(prod);
            idx_d   = idx_q + 1'b1;
            mphase_d = 2'd3;
            state_d = ST_MULT;
          end
          default: mphase_d = 2'd0;
        endcase
      end
      ST_DIV_L: begin
        if (sum_w_q == '0) begin
          mix_l_d = '0;
          state_d = ST_POST;
        end else if (div_ctrl.done) begin
          mix_l_d   = div_quo[15:0];
          div_start = 1'b1;
          div_num   = sum_r_q;
          state_d   = ST_DIV_R;
        end
      end
      ST_DIV_R: begin
        if (div_ctrl.done) begin
          prod_d  = {16'd0, div_quo[15:0]};
          state_d = ST_POST;
        end
      end
      ST_POST: begin
        shaped = shape(mix_l_q, last_l_q, limiter_q, slew_q);
        last_l_d = shaped;
        res_d.left_motor = motor(shaped, deadzone_q);
        shaped = shape((sum_w_q == '0) ? 16'd0 : prod_q[15:0], last_r_q,
                       limiter_q, slew_q);
        last_r_d = shaped;
        res_d.right_motor = motor(shaped, deadzone_q);
        res_d.frame_valid = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        res_d.active_count = 7'(count_q);
        valid_d2 = 1'b1;
        state_d  = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      valid_q  <= '0;
      count_q  <= '0;
      tick_q   <= '0;
      last_l_q <= '0;
      last_r_q <= '0;
      idx_q    <= '0;
      mphase_q <= '0;
      valid_q2 <= 1'b0;
    end else begin
      state_q  <= state_d;
      valid_q  <= valid_d;
      count_q  <= count_d;
      tick_q   <= tick_d;
      last_l_q <= last_l_d;
      last_r_q <= last_r_d;
      idx_q    <= idx_d;
      mphase_q <= mphase_d;
      valid_q2 <= valid_d2;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_l_q  <= sum_l_d;
    sum_r_q  <= sum_r_d;
    sum_w_q  <= sum_w_d;
    mix_l_q  <= mix_l_d;
    w_q      <= w_d;
    ducked_q <= ducked_d;
    prod_q   <= prod_d;
    item_q   <= item_d;
    res_q    <= res_d;
  end

  assign busy     = (state_q != ST_IDLE) || div_ctrl.busy;
  assign valid_o  = valid_q2;
  assign result_o = res_q;
endmodule

@@ bench/haptic_source_mixer_test.sv @@
// Self-checking testbench for the haptic source mixer: drives add and tick
// requests, predicts every result in a scoreboard class and compares them.
// Depends on hsm_pkg and haptic_source_mixer.
`timescale 1ns / 1ps

module haptic_source_mixer_test;
  import hsm_pkg::*;

  class mixer_scoreboard;
    // Source table and timing state of the predictor.
    bit                 slot_valid [64];
    logic [3:0]         slot_type  [64];
    logic [31:0]        slot_expiry[64];
    logic [15:0]        slot_left  [64];
    logic [15:0]        slot_right [64];
    logic [15:0]        slot_conf  [64];
    logic [31:0]        tick_cnt;
    logic [15:0]        held_left;
    logic [15:0]        held_right;
    // Register copies.
    logic               native_only;
    logic [15:0]        event_mask;
    logic               focus_on;
    logic [3:0]         focus_type;
    logic [15:0]        duck_gain;
    logic [15:0]        limiter;
    logic [7:0]         slew_steps;
    logic [15:0]        deadzone;
    out_item_t          frames_due[$];
    int                 error_count;

    function new();
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;
      tick_cnt    = '0;
      held_left   = '0;
      held_right  = '0;
      native_only = 1'b0;
      event_mask  = 16'hFFFF;
      focus_on    = 1'b0;
      focus_type  = '0;
      duck_gain   = 16'hFFFF;
      limiter     = 16'hFFFF;
      slew_steps  = 8'd255;
      deadzone    = '0;
      error_count = 0;
    endfunction

    function void set_register(reg_idx_e idx, logic [15:0] value);
      case (idx)
        REG_NATIVE_ONLY:  native_only = value[0];
        REG_ALLOWED_MASK: event_mask  = value;
        REG_FOCUS_ACTIVE: focus_on    = value[0];
        REG_FOCUS_TYPE:   focus_type  = value[3:0];
        REG_DUCK_GAIN:    duck_gain   = value;
        REG_LIMITER:      limiter     = value;
        REG_SLEW:         slew_steps  = value[7:0];
        REG_DEADZONE:     deadzone    = value;
        default: ;
      endcase
    endfunction

    function int pending();
      return frames_due.size();
    endfunction

    // Compressor above the 0.7 knee at 3:1.
    function logic [31:0] squash(logic [31:0] x);
      if (x <= 32'(CompThreshold)) return x;
      return 32'(CompThreshold) + (x - 32'(CompThreshold)) / 32'd3;
    endfunction

    function logic [31:0] slew_limit(logic [31:0] x, logic [31:0] prev);
      logic [31:0] step;
      step = 32'(slew_steps) * 32'd257;
      if (x > prev && x - prev > step) return prev + step;
      if (prev > x && prev - x > step) return prev - step;
      return x;
    endfunction

    function logic [7:0] motor_drive(logic [31:0] x);
      logic [63:0] scaled;
      scaled = 64'(x) * 64'd255 + 64'd255;
      return scaled[23:16];
    endfunction

    // Work out the frame that one accepted request must produce.
    function void note_request(in_item_t req);
      out_item_t   frame;
      bit          ok;
      logic [31:0] diff, w, mix_l, mix_r;
      logic [63:0] sum_l, sum_r, sum_w;
      int          held;
      frame = '0;
      if (req.op == 1'b0) begin
        ok = !native_only;
        if (ok && req.event_type != 4'd0 && !event_mask[req.event_type]) ok = 1'b0;
        if (ok) begin
          for (int i = 0; i < 64; i++) begin
            if (!slot_valid[i]) begin
              slot_valid[i]  = 1'b1;
              slot_type[i]   = req.event_type;
              slot_expiry[i] = tick_cnt - 32'(req.age_ticks) + 32'(req.ttl_ticks);
              slot_left[i]   = req.source_left;
              slot_right[i]  = req.source_right;
              slot_conf[i]   = req.confidence;
              frame.source_accepted = 1'b1;
              break;
            end
          end
        end
      end else begin
        tick_cnt = tick_cnt + 32'd1;
        // Drop sources whose expiry lies strictly in the past.
        for (int i = 0; i < 64; i++) begin
          diff = tick_cnt - slot_expiry[i];
          if (slot_valid[i] && diff != 0 && !diff[31]) slot_valid[i] = 1'b0;
        end
        sum_l = '0; sum_r = '0; sum_w = '0;
        for (int i = 0; i < 64; i++) begin
          if (slot_valid[i]) begin
            w = 32'(slot_conf[i]);
            if (focus_on && slot_type[i] != focus_type)
              w = 32'((64'(w) * (64'(duck_gain) + 64'd1)) >> 16);
            sum_l += 64'(slot_left[i]) * 64'(w);
            sum_r += 64'(slot_right[i]) * 64'(w);
            sum_w += 64'(w);
          end
        end
        mix_l = '0; mix_r = '0;
        if (sum_w != 0) begin
          mix_l = 32'(sum_l / sum_w);
          mix_r = 32'(sum_r / sum_w);
        end
        mix_l = squash(mix_l);
        mix_r = squash(mix_r);
        if (mix_l > 32'(limiter)) mix_l = 32'(limiter);
        if (mix_r > 32'(limiter)) mix_r = 32'(limiter);
        mix_l = slew_limit(mix_l, 32'(held_left));
        mix_r = slew_limit(mix_r, 32'(held_right));
        held_left  = mix_l[15:0];
        held_right = mix_r[15:0];
        if (mix_l < 32'(deadzone)) mix_l = '0;
        if (mix_r < 32'(deadzone)) mix_r = '0;
        frame.left_motor  = motor_drive(mix_l);
        frame.right_motor = motor_drive(mix_r);
        frame.frame_valid = 1'b1;
      end
      held = 0;
      foreach (slot_valid[i]) held += int'(slot_valid[i]);
      frame.active_count = held[6:0];
      frames_due.push_back(frame);
    endfunction

    function void check_frame(out_item_t got);
      out_item_t want;
      if (frames_due.size() == 0) begin
        $error("frame with no request outstanding: %h", got);
        error_count++;
        return;
      end
      want = frames_due.pop_front();
      if (got.left_motor !== want.left_motor) begin
        $error("left_motor expected %0d got %0d", want.left_motor, got.left_motor);
        error_count++;
      end
      if (got.right_motor !== want.right_motor) begin
        $error("right_motor expected %0d got %0d", want.right_motor, got.right_motor);
        error_count++;
      end
      if (got.frame_valid !== want.frame_valid) begin
        $error("frame_valid expected %0d got %0d", want.frame_valid, got.frame_valid);
        error_count++;
      end
      if (got.source_accepted !== want.source_accepted) begin
        $error("source_accepted expected %0d got %0d",
               want.source_accepted, got.source_accepted);
        error_count++;
      end
      if (got.active_count !== want.active_count) begin
        $error("active_count expected %0d got %0d", want.active_count, got.active_count);
        error_count++;
      end
    endfunction
  endclass

  localparam int StallLimit = 5000;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  in_item_t            item_i;
  logic                valid_o;
  out_item_t           result_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [15:0]         cfg_data_i;

  mixer_scoreboard     mixer_sb;
  logic [15:0]         settings[8];
  bit                  quiet_run;
  int                  stall_cycles;

  haptic_source_mixer u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .valid_o    (valid_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Result checking and the stall watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o) mixer_sb.check_frame(result_o);
      if (valid_o || (start && !busy)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Offer one request and hold it until taken, then idle now and again.
  task automatic push_request(input in_item_t req);
    start  <= 1'b1;
    item_i <= req;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    mixer_sb.note_request(req);
    if (!quiet_run && $urandom_range(3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(16, 1)) @(posedge clk_i);
    end
  endtask

  // Hold off until every frame is in and the block has gone idle.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (mixer_sb.pending() != 0 || busy) @(posedge clk_i);
  endtask

  // Write all eight registers from the settings array.
  task automatic program_settings();
    for (int i = 0; i < 8; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= reg_idx_e'(i);
      cfg_data_i <= settings[i];
      mixer_sb.set_register(reg_idx_e'(i), settings[i]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic in_item_t source_request(int ttl_max);
    in_item_t req;
    req.op           = 1'b0;
    req.event_type   = 4'($urandom_range(15));
    req.source_left  = 16'($urandom_range(65535));
    req.source_right = 16'($urandom_range(65535));
    req.confidence   = 16'($urandom_range(65535));
    // Mostly short lives so the table turns over; now and then any value.
    if ($urandom_range(7) == 0) begin
      req.ttl_ticks = 16'($urandom_range(65535));
      req.age_ticks = 16'($urandom_range(65535));
    end else begin
      req.ttl_ticks = 16'($urandom_range(ttl_max));
      req.age_ticks = 16'($urandom_range(2));
    end
    return req;
  endfunction

  function automatic in_item_t tick_request();
    in_item_t req;
    req    = source_request(65535);
    req.op = 1'b1;
    return req;
  endfunction

  function automatic in_item_t add_of(logic [3:0] et, logic [15:0] l, logic [15:0] r,
                                      logic [15:0] c, logic [15:0] ttl, logic [15:0] age);
    in_item_t req;
    req = '{1'b0, et, l, r, c, ttl, age};
    return req;
  endfunction

  initial begin
    in_item_t tick_item;
    mixer_sb   = new();
    rst_ni     = 1'b0;
    start      = 1'b0;
    item_i     = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    quiet_run  = 1'b0;
    stall_cycles = 0;
    tick_item  = '0;
    tick_item.op = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at reset settings: empty table, field extremes,
    // zero weight, immediate expiry and zero lifetime.
    push_request(tick_item);
    push_request(add_of(4'd0, 16'hFFFF, 16'h0000, 16'hFFFF, 16'd5, 16'd0));
    push_request(tick_item);
    push_request(add_of(4'd15, 16'h0000, 16'hFFFF, 16'hFFFF, 16'd3, 16'd0));
    push_request(add_of(4'd7, 16'hFFFF, 16'hFFFF, 16'h0000, 16'd4, 16'd0));
    push_request(tick_item);
    push_request(add_of(4'd2, 16'h8000, 16'h1234, 16'h4000, 16'd2, 16'd9));
    push_request(add_of(4'd3, 16'h7000, 16'h7000, 16'h0100, 16'd0, 16'd0));
    push_request(add_of(4'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    repeat (7) push_request(tick_item);

    // Phases of settings, the extremes first, then random ones.
    for (int phase = 0; phase < 6; phase++) begin
      drain();
      if (phase == 0) settings = '{16'd1, 16'h0000, 16'd1, 16'd15,
                                   16'h0000, 16'h0000, 16'd0, 16'hFFFF};
      else if (phase == 1) settings = '{16'd0, 16'hFFFF, 16'd1, 16'd0,
                                        16'h0000, 16'hFFFF, 16'd255, 16'h0000};
      else begin
        settings[REG_NATIVE_ONLY]  = 16'($urandom_range(5) == 0);
        settings[REG_ALLOWED_MASK] = 16'($urandom_range(65535));
        settings[REG_FOCUS_ACTIVE] = 16'($urandom_range(1));
        settings[REG_FOCUS_TYPE]   = 16'($urandom_range(15));
        settings[REG_DUCK_GAIN]    = 16'($urandom_range(65535));
        settings[REG_LIMITER]      = 16'($urandom_range(65535, 30000));
        settings[REG_SLEW]         = 16'($urandom_range(255));
        settings[REG_DEADZONE]     = 16'($urandom_range(20000));
      end
      program_settings();
      quiet_run = (phase == 5);
      for (int n = 0; n < 150; n++) begin
        if ($urandom_range(59) == 0) begin
          // Overfill the table with short-lived sources, then let them age.
          repeat (66) push_request(source_request(30));
          n += 66;
        end else if ($urandom_range(9) < 6) begin
          push_request(source_request(12));
        end else begin
          push_request(tick_request());
        end
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (mixer_sb.error_count == 0 && mixer_sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
